/* sv/hspf_pkg.sv */
// Package: shared constants, codes and the parse record type for the start-line filter.
`default_nettype none
package hspf_pkg;

    // Sizing
    localparam int URI_LIMIT     = 256;
    localparam int PAYLOAD_LIMIT = 1024;
    localparam int POS_W         = $clog2(PAYLOAD_LIMIT + 2);
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_W       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH   = 2'd2;

    // Method codes
    localparam logic [2:0] METH_NONE   = 3'd0;
    localparam logic [2:0] METH_GET    = 3'd1;
    localparam logic [2:0] METH_POST   = 3'd2;
    localparam logic [2:0] METH_PUT    = 3'd3;
    localparam logic [2:0] METH_DELETE = 3'd4;
    localparam logic [2:0] METH_HEAD   = 3'd5;

    // Message kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Version codes
    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_1_0  = 2'd1;
    localparam logic [1:0] VER_1_1  = 2'd2;
    localparam logic [1:0] VER_2_0  = 2'd3;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Text tokens, first character in the low byte (matches head byte order)
    localparam logic [23:0] TXT_GET    = 24'h544547;
    localparam logic [31:0] TXT_POST   = 32'h54534F50;
    localparam logic [23:0] TXT_PUT    = 24'h545550;
    localparam logic [47:0] TXT_DELETE = 48'h4554454C4544;
    localparam logic [31:0] TXT_HEAD   = 32'h44414548;
    localparam logic [31:0] TXT_HTTP   = 32'h50545448;
    localparam logic [63:0] TXT_V1_0   = 64'h302E312F50545448;
    localparam logic [63:0] TXT_V1_1   = 64'h312E312F50545448;
    localparam logic [63:0] TXT_V2_0   = 64'h302E322F50545448;

    // One parsed payload, before filtering
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  method;
        logic [1:0]  version;
        logic [9:0]  status;
        logic [31:0] hash;
        logic [7:0]  uri_len;
    } parse_rec_t;

    // Method from the head bytes; bytes not yet seen are zero and never match
    function automatic logic [2:0] method_of(input logic [63:0] head);
        logic [2:0] m;
        m = METH_NONE;
        if (head[23:0] == TXT_GET)
            m = METH_GET;
        else if (head[31:0] == TXT_POST)
            m = METH_POST;
        else if (head[23:0] == TXT_PUT)
            m = METH_PUT;
        else if (head[47:0] == TXT_DELETE)
            m = METH_DELETE;
        else if (head[31:0] == TXT_HEAD)
            m = METH_HEAD;
        return m;
    endfunction

    // First URI byte position for a method
    function automatic logic [2:0] uri_start_of(input logic [2:0] m);
        logic [2:0] s;
        case (m)
            METH_GET, METH_PUT:   s = 3'd4;
            METH_POST, METH_HEAD: s = 3'd5;
            METH_DELETE:          s = 3'd7;
            default:              s = 3'd7;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

/* sv/hspf_byte_if.sv */
// Interface: payload byte channel.
`default_nettype none
interface hspf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* sv/hspf_result_if.sv */
// Interface: parse result channel.
`default_nettype none
interface hspf_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [1:0]  message_kind;
    logic [2:0]  method_code;
    logic [1:0]  proto_version;
    logic [9:0]  status_value;
    logic [31:0] path_hash;
    logic [7:0]  uri_length;

    modport source (output valid, output accepted, output message_kind, output method_code,
                    output proto_version, output status_value, output path_hash,
                    output uri_length, input ready);
    modport sink   (input valid, input accepted, input message_kind, input method_code,
                    input proto_version, input status_value, input path_hash,
                    input uri_length, output ready);
endinterface
`default_nettype wire

/* sv/hspf_front.sv */
// Front end: per-byte start-line scan, emits one parse record per payload.
`default_nettype none
module hspf_front
    import hspf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hspf_byte_if.sink   payload,
    output parse_rec_t  rec,
    output logic        rec_valid,
    input  wire logic   rec_ready
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [63:0]      head_reg, head_next;
    logic [31:0]      hash_reg, hash_next;
    logic [7:0]       ucnt_reg, ucnt_next;
    logic             uclosed_reg, uclosed_next;
    logic             hstop_reg, hstop_next;
    logic [9:0]       stat_reg, stat_next;
    logic [1:0]       dcnt_reg, dcnt_next;
    logic             space_reg, space_next;
    logic             ddone_reg, ddone_next;

    logic       accept;
    logic [7:0] b;
    logic [2:0] m;
    logic       uri_win;
    logic [2:0] rm;
    logic [1:0] ver;

    assign payload.ready = rec_ready;
    assign accept        = payload.valid && rec_ready;
    assign b             = payload.data_byte;
    assign rec_valid     = accept && payload.last_byte;

    // Per-byte state update
    always_comb
    begin
        pos_next     = pos_reg;
        head_next    = head_reg;
        hash_next    = hash_reg;
        ucnt_next    = ucnt_reg;
        uclosed_next = uclosed_reg;
        hstop_next   = hstop_reg;
        stat_next    = stat_reg;
        dcnt_next    = dcnt_reg;
        space_next   = space_reg;
        ddone_next   = ddone_reg;

        m       = method_of(head_reg);
        uri_win = (m != METH_NONE)
                  && (pos_reg >= POS_W'(uri_start_of(m)))
                  && (32'(pos_reg) < 32'(URI_LIMIT))
                  && !uclosed_reg;

        // URI capture and hash
        if (uri_win)
        begin
            if (b == CH_SPACE)
            begin
                uclosed_next = 1'b1;
            end
            else
            begin
                if (ucnt_reg != 8'hFF)
                    ucnt_next = ucnt_reg + 8'd1;
                if (!hstop_reg)
                begin
                    if (b == CH_NUL)
                        hstop_next = 1'b1;
                    else
                        hash_next = (hash_reg << 5) - hash_reg + {{24{b[7]}}, b};
                end
            end
        end

        // Status digits after the first space past the version
        if (space_reg)
        begin
            if (!ddone_reg && dcnt_reg != 2'd3)
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    stat_next = (stat_reg << 3) + (stat_reg << 1) + {6'b0, b[3:0]};
                    dcnt_next = dcnt_reg + 2'd1;
                end
                else
                begin
                    ddone_next = 1'b1;
                end
            end
        end
        else if (32'(pos_reg) >= 32'd8 && b == CH_SPACE)
        begin
            space_next = 1'b1;
        end

        // First eight bytes
        if (32'(pos_reg) < 32'd8)
            head_next = head_reg | ({56'b0, b} << {pos_reg[2:0], 3'b000});

        // Saturating position
        if (32'(pos_reg) <= 32'(PAYLOAD_LIMIT))
            pos_next = pos_reg + POS_W'(1);
    end

    // Record for the payload ending on this beat
    always_comb
    begin
        rec = '0;
        rm  = method_of(head_next);
        ver = VER_NONE;
        if (head_next == TXT_V1_0)
            ver = VER_1_0;
        else if (head_next == TXT_V1_1)
            ver = VER_1_1;
        else if (head_next == TXT_V2_0)
            ver = VER_2_0;

        if (32'(pos_next) >= 32'd7 && 32'(pos_next) <= 32'(PAYLOAD_LIMIT))
        begin
            if (rm != METH_NONE)
            begin
                rec.kind    = KIND_REQUEST;
                rec.method  = rm;
                rec.version = VER_1_1;
                rec.hash    = hash_next;
                rec.uri_len = ucnt_next;
            end
            else if (32'(pos_next) >= 32'd12 && head_next[31:0] == TXT_HTTP && space_next
                     && ver != VER_NONE)
            begin
                rec.kind    = KIND_STATUS;
                rec.version = ver;
                rec.status  = stat_next;
            end
        end
    end

    // State registers, cleared after each last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            head_reg    <= '0;
            hash_reg    <= '0;
            ucnt_reg    <= '0;
            uclosed_reg <= 1'b0;
            hstop_reg   <= 1'b0;
            stat_reg    <= '0;
            dcnt_reg    <= '0;
            space_reg   <= 1'b0;
            ddone_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (payload.last_byte)
            begin
                pos_reg     <= '0;
                head_reg    <= '0;
                hash_reg    <= '0;
                ucnt_reg    <= '0;
                uclosed_reg <= 1'b0;
                hstop_reg   <= 1'b0;
                stat_reg    <= '0;
                dcnt_reg    <= '0;
                space_reg   <= 1'b0;
                ddone_reg   <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                head_reg    <= head_next;
                hash_reg    <= hash_next;
                ucnt_reg    <= ucnt_next;
                uclosed_reg <= uclosed_next;
                hstop_reg   <= hstop_next;
                stat_reg    <= stat_next;
                dcnt_reg    <= dcnt_next;
                space_reg   <= space_next;
                ddone_reg   <= ddone_next;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/hspf_queue.sv */
// Short record queue between front end and filter stage.
`default_nettype none
module hspf_queue
    import hspf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire parse_rec_t wr_rec,
    input  wire logic       wr_valid,
    output logic            wr_ready,
    output parse_rec_t      rd_rec,
    output logic            rd_valid,
    input  wire logic       rd_ready
);

    parse_rec_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               push, pop;

    assign wr_ready = (32'(cnt_reg) < 32'(Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_rec   = mem_reg[rptr_reg];

    // Pointer and count update
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (wptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + Q_PTR_W'(1);
        if (pop)
            rptr_next = (rptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + Q_PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_rec;
    end

endmodule
`default_nettype wire

/* sv/hspf_back.sv */
// Back end: filter registers, accept decision and output register.
`default_nettype none
module hspf_back
    import hspf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire parse_rec_t           rec,
    input  wire logic                 rec_valid,
    output logic                      rec_ready,
    hspf_result_if.source             result
);

    logic [3:0]  mfilt_reg;
    logic [9:0]  sfilt_reg;
    logic [31:0] hfilt_reg;

    logic        ovalid_reg;
    logic        acc_reg, acc_next;
    parse_rec_t  orec_reg;
    logic        load;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mfilt_reg <= '0;
            sfilt_reg <= '0;
            hfilt_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_METHOD: mfilt_reg <= cfg_data[3:0];
                CFG_STATUS: sfilt_reg <= cfg_data[9:0];
                CFG_HASH:   hfilt_reg <= cfg_data[31:0];
                default:    ;
            endcase
        end
    end

    // Filter decision
    always_comb
    begin
        acc_next = (rec.kind != KIND_NONE);
        if (mfilt_reg != 4'd0 && {1'b0, rec.method} != mfilt_reg)
            acc_next = 1'b0;
        if (sfilt_reg != 10'd0 && rec.status != sfilt_reg)
            acc_next = 1'b0;
        if (hfilt_reg != 32'd0 && rec.hash != hfilt_reg)
            acc_next = 1'b0;
    end

    // Output register; refills when empty or while the held beat is taken
    assign load      = !ovalid_reg || result.ready;
    assign rec_ready = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (load)
            ovalid_reg <= rec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && rec_valid)
        begin
            acc_reg  <= acc_next;
            orec_reg <= rec;
        end
    end

    assign result.valid         = ovalid_reg;
    assign result.accepted      = acc_reg;
    assign result.message_kind  = orec_reg.kind;
    assign result.method_code   = orec_reg.method;
    assign result.proto_version = orec_reg.version;
    assign result.status_value  = orec_reg.status;
    assign result.path_hash     = orec_reg.hash;
    assign result.uri_length    = orec_reg.uri_len;

endmodule
`default_nettype wire

/* sv/http_start_line_parse_filter.sv */
// Top level: HTTP start-line parser and filter over a TCP payload byte stream.
//
//   channel   dir   content
//   payload   in    data_byte[7:0], last_byte; one byte per beat
//   result    out   accepted, message_kind, method_code, proto_version,
//                   status_value, path_hash, uri_length; one beat per payload
//   cfg_*     in    write-only filter registers: method, status, URI hash
//
// One payload byte is taken every cycle while payload.ready is high. The front
// end updates its scan state in the cycle a byte is taken; the byte with
// last_byte pushes a record into a two-entry queue for the filter stage to register.
// Reset clears all scan state, the queue and the filter registers.
// payload.ready drops only when the queue is full because result is stalled.
`default_nettype none
module http_start_line_parse_filter
    import hspf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    hspf_byte_if.sink                 payload,
    hspf_result_if.source             result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    parse_rec_t f_rec, q_rec;
    logic       f_valid, f_ready;
    logic       q_valid, q_ready;

    hspf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .payload   (payload),
        .rec       (f_rec),
        .rec_valid (f_valid),
        .rec_ready (f_ready)
    );

    hspf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_rec   (f_rec),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_rec   (q_rec),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    hspf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec       (q_rec),
        .rec_valid (q_valid),
        .rec_ready (q_ready),
        .result    (result)
    );

endmodule
`default_nettype wire

/* bench/tb_http_start_line_parse_filter.sv */
// Testbench: random and directed payload streams against a scoreboard for the start-line filter.
`timescale 1ns / 1ps

import hspf_pkg::*;

// Expected or observed outcome of one payload
typedef struct packed {
    logic        accepted;
    logic [1:0]  kind;
    logic [2:0]  method;
    logic [1:0]  version;
    logic [9:0]  status;
    logic [31:0] hash;
    logic [7:0]  ulen;
} parse_verdict_t;

// One step of the URI hash: times 31 plus the sign-extended byte
function automatic logic [31:0] path_hash_step(input logic [31:0] h, input logic [7:0] b);
    return h * 32'd31 + {{24{b[7]}}, b};
endfunction

// Tracks the scan state of the payload in flight and the verdicts still owed
class verdict_board;
    logic [3:0]     method_sel;
    logic [9:0]     status_sel;
    logic [31:0]    hash_sel;

    int unsigned    pos;
    logic [63:0]    head;
    logic [31:0]    hash_acc;
    int unsigned    uri_cnt;
    bit             uri_closed;
    bit             hash_halted;
    int unsigned    status_acc;
    int unsigned    digit_cnt;
    bit             space_seen;
    bit             digits_done;

    parse_verdict_t awaited[$];
    int unsigned    failures;

    function new();
        method_sel = '0;
        status_sel = '0;
        hash_sel   = '0;
        failures   = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        pos         = 0;
        head        = '0;
        hash_acc    = '0;
        uri_cnt     = 0;
        uri_closed  = 0;
        hash_halted = 0;
        status_acc  = 0;
        digit_cnt   = 0;
        space_seen  = 0;
        digits_done = 0;
    endfunction

    // Token match against the first bytes seen so far
    function bit head_is(int unsigned known, string tok);
        if (tok.len() > known)
            return 0;
        for (int i = 0; i < tok.len(); i++)
            if (head[8*i +: 8] != tok[i])
                return 0;
        return 1;
    endfunction

    function logic [2:0] method_seen(int unsigned known);
        if (head_is(known, "GET"))    return METH_GET;
        if (head_is(known, "POST"))   return METH_POST;
        if (head_is(known, "PUT"))    return METH_PUT;
        if (head_is(known, "DELETE")) return METH_DELETE;
        if (head_is(known, "HEAD"))   return METH_HEAD;
        return METH_NONE;
    endfunction

    function int unsigned uri_first(logic [2:0] m);
        case (m)
            METH_GET, METH_PUT:   return 4;
            METH_POST, METH_HEAD: return 5;
            default:              return 7;
        endcase
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_METHOD: method_sel = val[3:0];
            CFG_STATUS: status_sel = val[9:0];
            CFG_HASH:   hash_sel   = val;
            default:    ;
        endcase
    endfunction

    // One accepted payload beat
    function void note_byte(logic [7:0] b, bit last);
        int unsigned    p;
        int unsigned    known;
        int unsigned    k;
        logic [2:0]     m;
        logic [2:0]     rm;
        parse_verdict_t v;

        p     = pos;
        known = (p < 8) ? p : 8;
        m     = method_seen(known);

        // URI capture, up to the first space inside the URI window
        if (m != METH_NONE && p >= uri_first(m) && p < URI_LIMIT && !uri_closed) begin
            if (b == CH_SPACE) begin
                uri_closed = 1;
            end
            else begin
                if (uri_cnt < 255)
                    uri_cnt++;
                if (!hash_halted) begin
                    if (b == CH_NUL)
                        hash_halted = 1;
                    else
                        hash_acc = path_hash_step(hash_acc, b);
                end
            end
        end

        // status digits after the first space at position 8 or later
        if (space_seen) begin
            if (!digits_done && digit_cnt < 3) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    status_acc = status_acc * 10 + (b - CH_ZERO);
                    digit_cnt++;
                end
                else begin
                    digits_done = 1;
                end
            end
        end
        else if (p >= 8 && b == CH_SPACE) begin
            space_seen = 1;
        end

        if (p < 8)
            head[8*p +: 8] = b;
        if (pos <= PAYLOAD_LIMIT)
            pos++;

        if (!last)
            return;

        v = '0;
        if (pos >= 7 && pos <= PAYLOAD_LIMIT) begin
            k  = (pos < 8) ? pos : 8;
            rm = method_seen(k);
            if (rm != METH_NONE) begin
                v.kind    = KIND_REQUEST;
                v.method  = rm;
                v.version = VER_1_1;
                v.hash    = hash_acc;
                v.ulen    = uri_cnt[7:0];
            end
            else if (pos >= 12 && head_is(k, "HTTP") && space_seen) begin
                if (head_is(k, "HTTP/1.0"))
                    v.version = VER_1_0;
                else if (head_is(k, "HTTP/1.1"))
                    v.version = VER_1_1;
                else if (head_is(k, "HTTP/2.0"))
                    v.version = VER_2_0;
                if (v.version != VER_NONE) begin
                    v.kind   = KIND_STATUS;
                    v.status = status_acc[9:0];
                end
            end
        end

        // filters
        if (v.kind != KIND_NONE) begin
            v.accepted = 1'b1;
            if (method_sel != 4'd0 && method_sel != {1'b0, v.method})
                v.accepted = 1'b0;
            if (status_sel != 10'd0 && status_sel != v.status)
                v.accepted = 1'b0;
            if (hash_sel != 32'd0 && hash_sel != v.hash)
                v.accepted = 1'b0;
        end

        awaited.push_back(v);
        clear_scan();
    endfunction

    function void check_result(parse_verdict_t got);
        parse_verdict_t exp;
        bit             bad;

        if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("ERROR: result beat with none pending: acc=%0d kind=%0d meth=%0d",
                         got.accepted, got.kind, got.method);
            return;
        end
        exp = awaited.pop_front();
        bad = (got.accepted !== exp.accepted) || (got.kind !== exp.kind)
           || (got.method !== exp.method) || (got.version !== exp.version)
           || (got.status !== exp.status) || (got.hash !== exp.hash)
           || (got.ulen !== exp.ulen);
        if (bad) begin
            failures++;
            if (failures <= 10) begin
                $display("ERROR: exp acc=%0d kind=%0d meth=%0d ver=%0d status=%0d hash=%08h len=%0d",
                         exp.accepted, exp.kind, exp.method, exp.version, exp.status,
                         exp.hash, exp.ulen);
                $display("       got acc=%0d kind=%0d meth=%0d ver=%0d status=%0d hash=%08h len=%0d",
                         got.accepted, got.kind, got.method, got.version, got.status,
                         got.hash, got.ulen);
            end
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module tb_http_start_line_parse_filter;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_BYTES  = 120;
    localparam int PHASE_COUNT  = 6;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    hspf_byte_if   pay_if();
    hspf_result_if res_if();

    verdict_board board;
    int           cycle_count = 0;
    int           burst_left;

    http_start_line_parse_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .payload   (pay_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // cycle count and watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check accepted beats, then pick next ready from a rotating pattern
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready)
            board.check_result('{res_if.accepted, res_if.message_kind, res_if.method_code,
                                 res_if.proto_version, res_if.status_value, res_if.path_hash,
                                 res_if.uri_length});
        case ((cycle_count / 97) % 4)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= (cycle_count % 4) != 0;
            2:       res_if.ready <= 1'($urandom_range(0, 1));
            default: res_if.ready <= (cycle_count % 20) < 4;
        endcase
    end

    // ---------------------------------------------------------------
    // payload building
    // ---------------------------------------------------------------
    function automatic void add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    // mostly printable, now and then a NUL, a high byte or anything at all
    function automatic logic [7:0] uri_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return CH_NUL;
        if (r < 8)
            return 8'($urandom_range(128, 255));
        if (r < 10)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic void make_request(ref logic [7:0] q[$], input int unsigned uri_len);
        string names[5];
        names = '{"GET", "POST", "PUT", "DELETE", "HEAD"};
        add_text(q, names[$urandom_range(0, 4)]);
        add_text(q, " ");
        if (uri_len == 0) begin
            add_text(q, "/index.html");
        end
        else begin
            q.push_back("/");
            repeat (uri_len)
                q.push_back(uri_byte());
        end
        case ($urandom_range(0, 3))
            0:       ;
            1:       add_text(q, " HTTP/1.1\015\n");
            2:       add_text(q, " HTTP/1.0\015\nHost: x\015\n\015\n");
            default: repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic void make_status(ref logic [7:0] q[$]);
        string       vers[10];
        string       codes[8];
        int unsigned r;
        vers  = '{"HTTP/1.0", "HTTP/1.0", "HTTP/1.0", "HTTP/1.1", "HTTP/1.1", "HTTP/1.1",
                  "HTTP/2.0", "HTTP/2.0", "HTTP/1.2", "HTTP/3.0"};
        codes = '{"200", "404", "999", "000", "1234", "5", "", "31"};
        add_text(q, vers[$urandom_range(0, 9)]);
        r = $urandom_range(0, 9);
        if (r < 8)
            add_text(q, " ");
        else if (r == 8)
            add_text(q, "  ");
        r = $urandom_range(0, 8);
        if (r < 8)
            add_text(q, codes[r]);
        else
            repeat (3) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        case ($urandom_range(0, 3))
            0:       ;
            1:       add_text(q, " OK");
            2:       add_text(q, " OK\015\n");
            default: repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic void make_random_payload(ref logic [7:0] q[$]);
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            // long URI, which may run past the capture window
            make_request(q, $urandom_range(200, 320));
        end
        else if (r < 45) begin
            make_request(q, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20));
        end
        else if (r < 80) begin
            make_status(q);
        end
        else if (r < 90) begin
            // broken: a well-formed start cut short or with one byte hit
            if (r < 85)
                make_request(q, $urandom_range(1, 12));
            else
                make_status(q);
            if (r % 2 == 0) begin
                n = $urandom_range(1, q.size());
                while (q.size() > n)
                    void'(q.pop_back());
            end
            else begin
                q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        else begin
            repeat ($urandom_range(1, 40)) q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                pay_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        pay_if.valid     <= 1'b1;
        pay_if.data_byte <= b;
        pay_if.last_byte <= last;
        do
            @(posedge clk);
        while (!pay_if.ready);
        board.note_byte(b, last);
        burst_left--;
    endtask

    task automatic send_payload(input logic [7:0] q[$]);
        for (int i = 0; i < q.size(); i++)
            send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] q[$];
        add_text(q, s);
        send_payload(q);
    endtask

    // drop valid and wait for every owed verdict, plus the filter stage
    task automatic settle();
        pay_if.valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_filters(input logic [3:0] m, input logic [9:0] s,
                                   input logic [31:0] h);
        logic [CFG_IDX_W-1:0] idx[3];
        logic [CFG_W-1:0]     val[3];
        idx = '{CFG_METHOD, CFG_STATUS, CFG_HASH};
        val = '{{28'd0, m}, {22'd0, s}, h};
        for (int i = 0; i < 3; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            board.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_directed();
        logic [7:0] q[$];

        send_text("GET /index.html HTTP/1.1\015\n");
        send_text("POST /api/v1 HTTP/1.0");
        send_text("PUT /a b");
        send_text("DELETE /x HTTP/1.1");
        send_text("HEAD / HTTP/1.1");
        send_text("HTTP/1.0 200 OK");
        send_text("HTTP/1.1 404 Not Found");
        // shortest status line, and one byte short of it
        send_text("HTTP/2.0 999");
        send_text("HTTP/1.1 20");
        // shortest payload, and one byte short of it
        send_text("GET /ab");
        send_text("GET /a");
        // space with no digits, more than three digits, bad version, late space
        send_text("HTTP/1.1 OK!");
        send_text("HTTP/1.1 12345 Y");
        send_text("HTTP/1.2 200 OK");
        send_text("HTTP/1.1200 OK x");
        // NUL inside the URI stops the hash but not the length
        q = {};
        add_text(q, "GET /a");
        q.push_back(CH_NUL);
        add_text(q, "bc HTTP/1.1");
        send_payload(q);
        // negative bytes in the hash
        q = {};
        add_text(q, "GET /");
        q.push_back(8'hFF);
        q.push_back(8'h80);
        q.push_back(8'h7F);
        add_text(q, " x");
        send_payload(q);
        // single-byte payload, all-zero and all-ones payloads
        q = {8'hFF};
        send_payload(q);
        q = {};
        repeat (8) q.push_back(8'h00);
        send_payload(q);
        q = {};
        repeat (8) q.push_back(8'hFF);
        send_payload(q);
    endtask

    task automatic run_random(input int unsigned bytes);
        logic [7:0]  q[$];
        int unsigned sent;
        sent = 0;
        while (sent < bytes) begin
            q = {};
            make_random_payload(q);
            send_payload(q);
            sent += q.size();
        end
    endtask

    // main sequence
    initial begin
        logic [31:0] index_hash;
        string       index_uri;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        pay_if.valid     <= 1'b0;
        pay_if.data_byte <= '0;
        pay_if.last_byte <= 1'b0;
        burst_left = 0;
        board = new();

        index_uri  = "/index.html";
        index_hash = '0;
        for (int i = 0; i < index_uri.len(); i++)
            index_hash = path_hash_step(index_hash, index_uri[i]);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: program_filters({1'b0, METH_GET}, 10'd0, 32'd0);
                    2: program_filters(4'd0, 10'd200, 32'd0);
                    3: program_filters(4'd0, 10'd0, index_hash);
                    4: program_filters(4'd9, 10'd999, 32'hFFFF_FFFF);
                    default: program_filters({1'b0, METH_HEAD}, 10'd0, 32'd0);
                endcase
            end
            run_random(PHASE_BYTES);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
